### rtl/awl_pkg.sv
`default_nettype none
package awl_pkg;

  localparam int COORD_BITS = 12;
  localparam int WALK_BITS  = COORD_BITS + 1;
  localparam int FRAC_BITS  = 16;
  localparam int ACC_BITS   = FRAC_BITS + 1;
  localparam int GRAY_BITS  = 8;
  localparam int CNT_BITS   = $clog2(ACC_BITS);

  // 1.0 in the error accumulator format
  localparam logic [ACC_BITS-1:0] ONE_FX = {1'b1, {FRAC_BITS{1'b0}}};

  typedef enum logic [1:0] {
    OP_MOVE = 2'd0,
    OP_LINE = 2'd1,
    OP_TICK = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    LC_VERT      = 3'd0,
    LC_STEEP_POS = 3'd1,
    LC_SHAL_POS  = 3'd2,
    LC_SHAL_NEG  = 3'd3,
    LC_STEEP_NEG = 3'd4
  } line_case_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DIV  = 1'b1
  } state_t;

  typedef struct packed {
    logic                  start;
    logic [COORD_BITS-1:0] minor;
    logic [COORD_BITS-1:0] major;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [ACC_BITS-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic [WALK_BITS-1:0] x;
    logic [WALK_BITS-1:0] y;
    logic [ACC_BITS-1:0]  err;
  } walk_t;

  typedef struct packed {
    logic [WALK_BITS-1:0] first_x;
    logic [WALK_BITS-1:0] first_y;
    logic [GRAY_BITS-1:0] first_gray;
    logic [WALK_BITS-1:0] second_x;
    logic [WALK_BITS-1:0] second_y;
    logic [GRAY_BITS-1:0] second_gray;
    logic                 second_valid;
    logic                 last;
  } pix_t;

  // floor(f * 255) in integer gray levels, f in accumulator format
  function automatic logic [GRAY_BITS-1:0] gray_of(input logic [ACC_BITS-1:0] f);
    logic [ACC_BITS+GRAY_BITS-1:0] prod;
    begin
      prod = {f, {GRAY_BITS{1'b0}}} - {{GRAY_BITS{1'b0}}, f};
      return prod[FRAC_BITS+GRAY_BITS-1:FRAC_BITS];
    end
  endfunction

endpackage
`default_nettype wire

### rtl/awl_if.sv
`default_nettype none
interface awl_in_if import awl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            op;
  logic [COORD_BITS-1:0] x;
  logic [COORD_BITS-1:0] y;

  modport source (output valid, output op, output x, output y, input ready);
  modport sink   (input valid, input op, input x, input y, output ready);
endinterface

interface awl_out_if import awl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [WALK_BITS-1:0] first_x;
  logic [WALK_BITS-1:0] first_y;
  logic [GRAY_BITS-1:0] first_gray;
  logic [WALK_BITS-1:0] second_x;
  logic [WALK_BITS-1:0] second_y;
  logic [GRAY_BITS-1:0] second_gray;
  logic                 second_valid;
  logic                 last;

  modport source (output valid, output first_x, output first_y, output first_gray,
                  output second_x, output second_y, output second_gray,
                  output second_valid, output last, input ready);
  modport sink   (input valid, input first_x, input first_y, input first_gray,
                  input second_x, input second_y, input second_gray,
                  input second_valid, input last, output ready);
endinterface
`default_nettype wire

### rtl/awl_div.sv
`default_nettype none
module awl_div import awl_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic                  busy_r, busy_nxt;
  logic [CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic [WALK_BITS-1:0]  rem_r, rem_nxt;
  logic [ACC_BITS-1:0]   quo_r, quo_nxt;
  logic [COORD_BITS-1:0] major_r, major_nxt;
  logic [WALK_BITS-1:0]  trial;
  logic [WALK_BITS-1:0]  diff;
  logic                  bit_q;
  logic                  final_step;

  // one compare-subtract per cycle, integer bit first then fraction bits
  always_comb begin
    trial      = (cnt_r == '0) ? rem_r : {rem_r[WALK_BITS-2:0], 1'b0};
    bit_q      = trial >= {1'b0, major_r};
    diff       = trial - {1'b0, major_r};
    final_step = busy_r && (cnt_r == CNT_BITS'(ACC_BITS - 1));
  end

  always_comb begin
    busy_nxt  = busy_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    major_nxt = major_r;
    if (req.start) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = '0;
      rem_nxt   = {1'b0, req.minor};
      major_nxt = req.major;
    end else if (busy_r) begin
      rem_nxt = bit_q ? diff : trial;
      quo_nxt = {quo_r[ACC_BITS-2:0], bit_q};
      cnt_nxt = cnt_r + CNT_BITS'(1);
      if (final_step) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    major_r <= major_nxt;
  end

  assign rsp.done = final_step;
  assign rsp.quo  = {quo_r[ACC_BITS-2:0], bit_q};

endmodule
`default_nettype wire

### rtl/awl_pixel.sv
`default_nettype none
module awl_pixel import awl_pkg::*; (
  input  wire walk_t                 walk,
  input  wire logic [ACC_BITS-1:0]   slope,
  input  wire logic [COORD_BITS-1:0] stop,
  input  wire line_case_t            lcase,
  output pix_t                       pix,
  output walk_t                      walk_nxt
);

  logic [ACC_BITS:0]    sum;
  logic                 carry;
  logic [ACC_BITS-1:0]  err_adv;
  logic [WALK_BITS-1:0] x_inc, y_inc, y_dec;
  logic [WALK_BITS-1:0] major;

  always_comb begin
    sum     = {1'b0, walk.err} + {1'b0, slope};
    carry   = sum >= {1'b0, ONE_FX};
    err_adv = carry ? ACC_BITS'(sum - {1'b0, ONE_FX}) : sum[ACC_BITS-1:0];
    x_inc   = walk.x + WALK_BITS'(1);
    y_inc   = walk.y + WALK_BITS'(1);
    y_dec   = walk.y - WALK_BITS'(1);
  end

  always_comb begin
    pix              = '0;
    walk_nxt         = walk;
    pix.first_x      = walk.x;
    pix.first_y      = walk.y;
    pix.first_gray   = gray_of(ONE_FX - walk.err);
    pix.second_x     = walk.x;
    pix.second_y     = walk.y;
    pix.second_gray  = gray_of(walk.err);
    pix.second_valid = 1'b1;
    major            = walk.x;
    unique case (lcase)
      LC_VERT: begin
        pix.first_gray   = '0;
        pix.second_x     = '0;
        pix.second_y     = '0;
        pix.second_gray  = '0;
        pix.second_valid = 1'b0;
        walk_nxt.y       = y_inc;
        major            = y_inc;
      end
      LC_STEEP_POS: begin
        pix.first_x  = x_inc;
        walk_nxt.err = err_adv;
        walk_nxt.x   = carry ? x_inc : walk.x;
        walk_nxt.y   = y_inc;
        major        = y_inc;
      end
      LC_SHAL_POS: begin
        pix.first_y  = y_inc;
        walk_nxt.err = err_adv;
        walk_nxt.y   = carry ? y_inc : walk.y;
        walk_nxt.x   = x_inc;
        major        = x_inc;
      end
      LC_SHAL_NEG: begin
        pix.first_y  = y_dec;
        walk_nxt.err = err_adv;
        walk_nxt.y   = carry ? y_dec : walk.y;
        walk_nxt.x   = x_inc;
        major        = x_inc;
      end
      LC_STEEP_NEG: begin
        pix.first_x  = x_inc;
        walk_nxt.err = err_adv;
        walk_nxt.x   = carry ? x_inc : walk.x;
        walk_nxt.y   = y_dec;
        major        = y_dec;
      end
      default: begin
        pix.second_valid = 1'b0;
      end
    endcase
    pix.last = major == {1'b0, stop};
  end

endmodule
`default_nettype wire

### rtl/antialiased_line_rasterizer_unit.sv
`default_nettype none
// channel   | dir | payload                                             | handshake
// in_bus    | in  | op, x, y                                            | valid/ready
// out_bus   | out | first_x/y/gray, second_x/y/gray, second_valid, last | valid/ready
//
// a move or tick beat needs no divider; a tick of an active line loads the output register
// a non-vertical line beat starts a restoring divider that builds the slope,
//   one compare-subtract per cycle, integer bit then 16 fraction bits
// in_bus.ready is low while the divider runs and while an unread result blocks the output
// synchronous active-low reset clears the point, walk state, line flag and output valid
module antialiased_line_rasterizer_unit import awl_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  awl_in_if.sink    in_bus,
  awl_out_if.source out_bus
);

  // fsm
  state_t state_r, state_nxt;

  // current point and line walk state
  logic [COORD_BITS-1:0] start_x_r, start_x_nxt;
  logic [COORD_BITS-1:0] start_y_r, start_y_nxt;
  walk_t                 walk_r, walk_nxt;
  logic [COORD_BITS-1:0] stop_r, stop_nxt;
  logic [ACC_BITS-1:0]   slope_r, slope_nxt;
  line_case_t            case_r, case_nxt;
  logic                  active_r, active_nxt;

  // output register
  pix_t out_r, out_nxt;
  logic out_valid_r, out_valid_nxt;

  // handshake
  logic accept;
  logic out_free;
  logic is_move, is_line, is_tick;
  logic tick_fire;
  logic div_needed;

  // line setup terms
  logic [COORD_BITS-1:0] x0, y0, x1, y1;
  logic [COORD_BITS-1:0] adx, ady;
  logic                  same_dir, steep, zero_len;
  line_case_t            setup_case;
  logic [COORD_BITS-1:0] setup_wx, setup_wy, setup_stop;

  // shared divider and pixel datapath
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic     div_start;
  pix_t     pix;
  walk_t    walk_step;

  awl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  awl_pixel u_pixel (
    .walk     (walk_r),
    .slope    (slope_r),
    .stop     (stop_r),
    .lcase    (case_r),
    .pix      (pix),
    .walk_nxt (walk_step)
  );

  // decode of the input beat
  always_comb begin
    out_free  = !out_valid_r || out_bus.ready;
    accept    = in_bus.valid && in_bus.ready;
    is_move   = in_bus.op == OP_MOVE;
    is_line   = in_bus.op == OP_LINE;
    is_tick   = in_bus.op == OP_TICK;
    tick_fire = accept && is_tick && active_r;
  end

  // line setup: spans, direction, case and walk start
  always_comb begin
    x0       = start_x_r;
    y0       = start_y_r;
    x1       = in_bus.x;
    y1       = in_bus.y;
    adx      = (x0 > x1) ? x0 - x1 : x1 - x0;
    ady      = (y0 > y1) ? y0 - y1 : y1 - y0;
    same_dir = (x1 >= x0) == (y1 >= y0);
    steep    = ady > adx;
    zero_len = (adx == '0) && (ady == '0);
    if (adx == '0) begin
      setup_case = LC_VERT;
      setup_wx   = x0;
      setup_wy   = (y0 < y1) ? y0 : y1;
      setup_stop = (y0 < y1) ? y1 : y0;
    end else if (steep && same_dir) begin
      setup_case = LC_STEEP_POS;
      setup_wx   = (y0 < y1) ? x0 : x1;
      setup_wy   = (y0 < y1) ? y0 : y1;
      setup_stop = (y0 < y1) ? y1 : y0;
    end else if (steep) begin
      setup_case = LC_STEEP_NEG;
      setup_wx   = (x0 < x1) ? x0 : x1;
      setup_wy   = (x0 < x1) ? y0 : y1;
      setup_stop = (x0 < x1) ? y1 : y0;
    end else begin
      // horizontal lines walk as shallow positive
      setup_case = (same_dir || ady == '0) ? LC_SHAL_POS : LC_SHAL_NEG;
      setup_wx   = (x0 < x1) ? x0 : x1;
      setup_wy   = (x0 < x1) ? y0 : y1;
      setup_stop = (x0 < x1) ? x1 : x0;
    end
    div_needed    = is_line && !zero_len && (adx != '0);
    div_req.start = div_start;
    div_req.minor = steep ? adx : ady;
    div_req.major = steep ? ady : adx;
  end

  // fsm next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept && div_needed) state_nxt = ST_DIV;
      ST_DIV:  if (div_rsp.done) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_bus.ready = 1'b0;
    div_start    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_bus.ready = out_free;
        div_start    = in_bus.valid && out_free && div_needed;
      end
      ST_DIV:  ;
      default: ;
    endcase
  end

  // state updates
  always_comb begin
    start_x_nxt = start_x_r;
    start_y_nxt = start_y_r;
    walk_nxt    = walk_r;
    stop_nxt    = stop_r;
    slope_nxt   = slope_r;
    case_nxt    = case_r;
    active_nxt  = active_r;
    if (div_rsp.done) begin
      slope_nxt = div_rsp.quo;
    end
    if (accept && is_move) begin
      start_x_nxt = in_bus.x;
      start_y_nxt = in_bus.y;
    end
    if (accept && is_line) begin
      // any older line is dropped; a zero-length line only moves the point
      start_x_nxt  = x1;
      start_y_nxt  = y1;
      walk_nxt.err = '0;
      slope_nxt    = '0;
      active_nxt   = !zero_len;
      if (!zero_len) begin
        case_nxt   = setup_case;
        walk_nxt.x = {1'b0, setup_wx};
        walk_nxt.y = {1'b0, setup_wy};
        stop_nxt   = setup_stop;
      end
    end
    if (tick_fire) begin
      walk_nxt = walk_step;
      if (pix.last) begin
        active_nxt = 1'b0;
      end
    end
  end

  // output register: a tick of an active line loads one beat
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_bus.ready;
    if (tick_fire) begin
      out_nxt       = pix;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      start_x_r   <= '0;
      start_y_r   <= '0;
      walk_r      <= '0;
      stop_r      <= '0;
      slope_r     <= '0;
      case_r      <= LC_VERT;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_x_r   <= start_x_nxt;
      start_y_r   <= start_y_nxt;
      walk_r      <= walk_nxt;
      stop_r      <= stop_nxt;
      slope_r     <= slope_nxt;
      case_r      <= case_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.first_x      = out_r.first_x;
  assign out_bus.first_y      = out_r.first_y;
  assign out_bus.first_gray   = out_r.first_gray;
  assign out_bus.second_x     = out_r.second_x;
  assign out_bus.second_y     = out_r.second_y;
  assign out_bus.second_gray  = out_r.second_gray;
  assign out_bus.second_valid = out_r.second_valid;
  assign out_bus.last         = out_r.last;

endmodule
`default_nettype wire

### rtl/awl_chk.sv
`default_nettype none
module awl_chk import awl_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic [1:0]           in_op,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [WALK_BITS-1:0] out_second_x,
  input wire logic [GRAY_BITS-1:0] out_second_gray,
  input wire logic                 out_second_valid,
  input wire logic                 out_last
);

  // a held beat stays
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out beat dropped while stalled");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_last) && $stable(out_second_x))
    else $error("out payload changed while stalled");

  // new beats come only from an accepted tick
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(out_valid && !out_ready) |->
      $past(in_valid && in_ready && in_op == OP_TICK))
    else $error("out beat without a tick");

  // unread result blocks the input
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output full");

  // single-pixel beats carry an empty second pixel
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_second_valid |-> out_second_gray == '0 && out_second_x == '0)
    else $error("vertical beat with second pixel data");

endmodule

bind antialiased_line_rasterizer_unit awl_chk u_awl_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_bus.valid),
  .in_ready         (in_bus.ready),
  .in_op            (in_bus.op),
  .out_valid        (out_bus.valid),
  .out_ready        (out_bus.ready),
  .out_second_x     (out_bus.second_x),
  .out_second_gray  (out_bus.second_gray),
  .out_second_valid (out_bus.second_valid),
  .out_last         (out_bus.last)
);
`default_nettype wire

### bench/antialiased_line_rasterizer_unit_test.sv
`default_nettype none
module antialiased_line_rasterizer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import awl_pkg::*;

  // op code 3 has no meaning, the block must swallow it silently
  localparam logic [1:0] OP_IGNORED = 2'd3;
  // 1.0 with one spare bit so the accumulator can hold e + slope before the wrap
  localparam logic [ACC_BITS:0] UNITY = (ACC_BITS+1)'(1 << FRAC_BITS);
  localparam logic [COORD_BITS-1:0] COORD_MAX = '1;
  localparam int CYCLE_LIMIT = 400_000;
  // margin for the divider, the output register and a stalled receiver
  localparam int SETTLE_CYCLES = 60;

  logic clk;
  logic rst_n;

  awl_in_if  in_bus ();
  awl_out_if out_bus ();

  antialiased_line_rasterizer_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // pixel predictor state
  // ---------------------------------------------------------------------------
  logic [COORD_BITS-1:0] pen_x, pen_y;        // current point
  logic [WALK_BITS-1:0]  walk_x, walk_y;      // pixel the next tick draws
  logic [WALK_BITS-1:0]  stop_major;          // major coordinate where the line ends
  logic [ACC_BITS:0]     err_acc;             // coverage of the second pixel
  logic [ACC_BITS-1:0]   slope_inc;           // minor over major, 1.0 at most
  line_case_t            walk_case;
  bit                    drawing;

  pix_t pending_pixels[$];                    // expected beats, oldest first

  int fail_count = 0;
  int counted_beats;
  int cycle_count = 0;
  int send_idle_pct;
  int recv_idle_pct;

  // floor(f * 255), f in 2.16 fixed point
  function automatic logic [GRAY_BITS-1:0] gray_level(logic [ACC_BITS:0] f);
    logic [ACC_BITS+GRAY_BITS:0] prod;
    prod = {{GRAY_BITS{1'b0}}, f} * (ACC_BITS+GRAY_BITS+1)'(255);
    return prod[FRAC_BITS+GRAY_BITS-1:FRAC_BITS];
  endfunction

  // line setup: span, slope, case, walking start and end
  function automatic void start_line(logic [COORD_BITS-1:0] x1, logic [COORD_BITS-1:0] y1);
    logic [COORD_BITS-1:0]           x0, y0, adx, ady;
    logic [COORD_BITS+FRAC_BITS-1:0] num;
    bit                              same_dir;
    x0       = pen_x;
    y0       = pen_y;
    adx      = (x0 > x1) ? x0 - x1 : x1 - x0;
    ady      = (y0 > y1) ? y0 - y1 : y1 - y0;
    same_dir = ((x1 >= x0) == (y1 >= y0));
    pen_x     = x1;
    pen_y     = y1;
    err_acc   = '0;
    slope_inc = '0;
    drawing   = 1'b0;
    // zero-length line draws nothing, the point still moves
    if (adx == 0 && ady == 0) return;
    if (adx == 0) begin
      walk_case  = LC_VERT;
      walk_x     = WALK_BITS'(x0);
      walk_y     = WALK_BITS'((y0 < y1) ? y0 : y1);
      stop_major = WALK_BITS'((y0 < y1) ? y1 : y0);
    end else if (ady > adx) begin
      num       = {adx, {FRAC_BITS{1'b0}}};
      slope_inc = ACC_BITS'(num / ady);
      if (same_dir) begin
        walk_case  = LC_STEEP_POS;
        walk_x     = WALK_BITS'((y0 < y1) ? x0 : x1);
        walk_y     = WALK_BITS'((y0 < y1) ? y0 : y1);
        stop_major = WALK_BITS'((y0 < y1) ? y1 : y0);
      end else begin
        // walk runs left to right, y falling
        walk_case  = LC_STEEP_NEG;
        walk_x     = WALK_BITS'((x0 < x1) ? x0 : x1);
        walk_y     = WALK_BITS'((x0 < x1) ? y0 : y1);
        stop_major = WALK_BITS'((x0 < x1) ? y1 : y0);
      end
    end else begin
      num        = {ady, {FRAC_BITS{1'b0}}};
      slope_inc  = ACC_BITS'(num / adx);
      // horizontal lines take the positive shallow path
      walk_case  = (same_dir || ady == 0) ? LC_SHAL_POS : LC_SHAL_NEG;
      walk_x     = WALK_BITS'((x0 < x1) ? x0 : x1);
      walk_y     = WALK_BITS'((x0 < x1) ? y0 : y1);
      stop_major = WALK_BITS'((x0 < x1) ? x1 : x0);
    end
    drawing = 1'b1;
  endfunction

  // one tick of an active line: build the pixel pair and advance the walk
  function automatic void step_line();
    pix_t                 pix;
    logic [ACC_BITS:0]    e;
    logic [WALK_BITS-1:0] major;
    bit                   carry;
    if (!drawing) return;
    pix = '0;
    if (walk_case == LC_VERT) begin
      // single black pixel, second slot stays zero
      pix.first_x = walk_x;
      pix.first_y = walk_y;
      walk_y      = walk_y + 1'b1;
      major       = walk_y;
    end else begin
      pix.first_gray   = gray_level(UNITY - err_acc);
      pix.second_gray  = gray_level(err_acc);
      pix.first_x      = walk_x;
      pix.first_y      = walk_y;
      case (walk_case)
        LC_STEEP_POS, LC_STEEP_NEG: pix.first_x = walk_x + 1'b1;
        LC_SHAL_POS:                pix.first_y = walk_y + 1'b1;
        default:                    pix.first_y = walk_y - 1'b1;
      endcase
      pix.second_x     = walk_x;
      pix.second_y     = walk_y;
      pix.second_valid = 1'b1;
      e     = err_acc + slope_inc;
      carry = (e >= UNITY);
      if (carry) e = e - UNITY;
      err_acc = e;
      case (walk_case)
        LC_STEEP_POS: begin
          if (carry) walk_x = walk_x + 1'b1;
          walk_y = walk_y + 1'b1;
          major  = walk_y;
        end
        LC_SHAL_POS: begin
          if (carry) walk_y = walk_y + 1'b1;
          walk_x = walk_x + 1'b1;
          major  = walk_x;
        end
        LC_SHAL_NEG: begin
          if (carry) walk_y = walk_y - 1'b1;
          walk_x = walk_x + 1'b1;
          major  = walk_x;
        end
        default: begin
          if (carry) walk_x = walk_x + 1'b1;
          walk_y = walk_y - 1'b1;
          major  = walk_y;
        end
      endcase
    end
    // end pixel itself is never drawn
    if (major == stop_major) begin
      drawing  = 1'b0;
      pix.last = 1'b1;
    end
    pending_pixels.push_back(pix);
  endfunction

  // ---------------------------------------------------------------------------
  // input driver: changes at the falling edge, acceptance seen at the rising edge
  // ---------------------------------------------------------------------------
  task automatic send_beat(logic [1:0] op, logic [COORD_BITS-1:0] x,
                           logic [COORD_BITS-1:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid = 1'b0;
      in_bus.op    = 2'($urandom);
      in_bus.x     = COORD_BITS'($urandom);
      in_bus.y     = COORD_BITS'($urandom);
      @(negedge clk);
    end
    in_bus.valid = 1'b1;
    in_bus.op    = op;
    in_bus.x     = x;
    in_bus.y     = y;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    // ignored op codes and ticks with no line don't count toward the stimulus size
    if (op == OP_MOVE || op == OP_LINE || (op == OP_TICK && drawing)) counted_beats++;
    case (op)
      OP_MOVE: begin
        pen_x = x;
        pen_y = y;
      end
      OP_LINE: start_line(x, y);
      OP_TICK: step_line();
      default: ;
    endcase
    // valid stays up here; the next call either holds it or idles it
    @(negedge clk);
  endtask

  // hold the sender off until every predicted pixel has come out
  task automatic wait_for_drain();
    in_bus.valid = 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
  endtask

  task automatic tick_until_done();
    while (drawing) send_beat(OP_TICK, COORD_BITS'($urandom), COORD_BITS'($urandom));
  endtask

  // move a coordinate by off in a random direction, flipping it at the edges
  function automatic logic [COORD_BITS-1:0] nudge(logic [COORD_BITS-1:0] base, int off);
    int b;
    b = int'(base);
    if ($urandom_range(1) == 1)
      return (b + off <= COORD_MAX) ? COORD_BITS'(b + off) : COORD_BITS'(b - off);
    return (b >= off) ? COORD_BITS'(b - off) : COORD_BITS'(b + off);
  endfunction

  // ---------------------------------------------------------------------------
  // receiver: random stalls, then compare each beat against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    pix_t want;
    if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (pending_pixels.size() == 0) begin
        $error("pixel beat with nothing pending: first (%0d,%0d)",
               out_bus.first_x, out_bus.first_y);
        fail_count++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("first_x",      want.first_x,      out_bus.first_x);
        check_field("first_y",      want.first_y,      out_bus.first_y);
        check_field("first_gray",   want.first_gray,   out_bus.first_gray);
        check_field("second_x",     want.second_x,     out_bus.second_x);
        check_field("second_y",     want.second_y,     out_bus.second_y);
        check_field("second_gray",  want.second_gray,  out_bus.second_gray);
        check_field("second_valid", want.second_valid, out_bus.second_valid);
        check_field("last",         want.last,         out_bus.last);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // hand-picked strokes: each case, coordinate extremes and the corner behaviors
  task automatic test_directed_strokes();
    send_idle_pct = 21;
    recv_idle_pct = 65;
    send_beat(OP_TICK, COORD_MAX, '0);          // nothing active, no beat
    send_beat(OP_IGNORED, COORD_MAX, COORD_MAX);
    send_beat(OP_LINE, '0, '0);                 // zero length from reset point
    send_beat(OP_TICK, '0, '0);
    send_beat(OP_LINE, '0, 12'd2);              // vertical, two black pixels
    tick_until_done();
    send_beat(OP_TICK, '0, '0);                 // line finished, no beat
    // near full-span shallow line, a couple of pixels then dropped
    send_beat(OP_LINE, COORD_MAX, COORD_MAX);
    send_beat(OP_TICK, '0, '0);
    send_beat(OP_TICK, '0, '0);
    // full-width horizontal at the top row replaces it, first_y runs past the range
    send_beat(OP_LINE, '0, COORD_MAX);
    send_beat(OP_TICK, '0, '0);
    // move mid-line only changes the point, the walk carries on
    send_beat(OP_MOVE, COORD_MAX, '0);
    wait_for_drain();
    send_beat(OP_TICK, '0, '0);
    send_beat(OP_LINE, 12'd4094, 12'd4);        // steep negative at the right edge
    tick_until_done();
    send_beat(OP_MOVE, 12'd2, COORD_MAX);
    send_beat(OP_LINE, 12'd5, 12'd4093);        // shallow negative at the top edge
    tick_until_done();
    send_beat(OP_MOVE, 12'd4094, '0);
    send_beat(OP_LINE, COORD_MAX, 12'd3);       // steep positive
    tick_until_done();
    send_beat(OP_LINE, 12'd4092, '0);           // exact diagonal, slope of one
    tick_until_done();
  endtask

  // random strokes, mostly well formed, some noise and abandoned lines
  task automatic test_random_strokes(int beats, int send_pct, int recv_pct);
    int target, span, shape, off;
    logic [COORD_BITS-1:0] ex, ey;
    logic [1:0] op;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    target = counted_beats + beats;
    while (counted_beats < target) begin
      if ($urandom_range(99) < 80) begin
        if ($urandom_range(3) != 0)
          send_beat(OP_MOVE, COORD_BITS'($urandom), COORD_BITS'($urandom));
        span  = ($urandom_range(19) == 0) ? 200 : 16;
        shape = $urandom_range(9);
        off   = $urandom_range(0, span);
        // shape 0 vertical, 1 horizontal, 2 diagonal, rest anything
        ex = nudge(pen_x, (shape == 0) ? 0 : off);
        if (shape == 1)      ey = pen_y;
        else if (shape == 2) ey = nudge(pen_y, off);
        else                 ey = nudge(pen_y, $urandom_range(0, span));
        send_beat(OP_LINE, ex, ey);
        while (drawing) begin
          if ($urandom_range(29) == 0) break;     // abandon, next line drops it
          if ($urandom_range(49) == 0) wait_for_drain();
          send_beat(OP_TICK, COORD_BITS'($urandom), COORD_BITS'($urandom));
        end
      end else begin
        op = 2'($urandom_range(3));
        send_beat(op, COORD_BITS'($urandom), COORD_BITS'($urandom));
        if (op == OP_LINE) begin
          repeat ($urandom_range(0, 5))
            send_beat(OP_TICK, COORD_BITS'($urandom), COORD_BITS'($urandom));
        end
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.op      = OP_MOVE;
    in_bus.x       = '0;
    in_bus.y       = '0;
    pen_x          = '0;
    pen_y          = '0;
    walk_x         = '0;
    walk_y         = '0;
    stop_major     = '0;
    err_acc        = '0;
    slope_inc      = '0;
    walk_case      = LC_VERT;
    drawing        = 1'b0;
    counted_beats  = 0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    test_directed_strokes();
    test_random_strokes(200, 21, 65);
    test_random_strokes(200, 65, 21);
    test_random_strokes(200, 0, 0);

    // let the pipe empty, then watch for stray beats
    in_bus.valid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
